>>> src/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, quiet while reset is held
`define RAUS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion that also checks across reset
`define RAUS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/raus_pkg.sv
// shared constants and types for the range affine update / range sum unit
`timescale 1ns / 1ps

package raus_pkg;

  localparam int DEF_LEAVES = 1024;
  localparam int DEF_WIDTH  = 32;
  localparam int ACT_W      = 2;
  localparam int IDX_W      = 10;
  localparam int OPND_W     = 32;
  localparam int OUT_W      = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_MUL   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_RSVD  = 2'd3
  } action_e;

endpackage

>>> src/raus_ram.sv
// simple dual port node memory, one write and one registered read per cycle
`timescale 1ns / 1ps

module raus_ram #(
  parameter int AW = 11,
  parameter int DW = 96
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/range_affine_update_range_sum_unit.sv
// lazy segment tree with range add, range multiply and range sum queries
//
// Usage:
//   Input requests (action_i, range_low_i, range_high_i, operand_i) are taken
//   on in_valid_i && in_ready_o. Action add adds operand_i to every element of
//   the inclusive range, multiply scales it, query returns the range sum on
//   range_sum_o with out_valid_o / out_ready_i. Updates give no result.
//   All arithmetic wraps modulo 2^WIDTH; an empty range changes nothing and a
//   query over it returns 0. Unused action codes are dropped.
//   One request is worked at a time. A request walks the tree top-down
//   pushing pending maps, covers up to two nodes per level, then refreshes
//   the parent sums, all through the single node memory; empty requests
//   skip the walk.
//   After reset the node memory is swept and in_ready_o stays low meanwhile.
//   A finished query result waits in the output register; while it is
//   stalled a following request is still taken and worked, and the block
//   holds before delivering its next result.
`timescale 1ns / 1ps

module range_affine_update_range_sum_unit
  import raus_pkg::*;
#(
  parameter int LEAVES = DEF_LEAVES,
  parameter int WIDTH  = DEF_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [IDX_W-1:0]  range_low_i,
  input  logic [IDX_W-1:0]  range_high_i,
  input  logic [OPND_W-1:0] operand_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  range_sum_o
);

  localparam int LOG = $clog2(LEAVES);
  localparam int SZ  = 1 << LOG;
  localparam int AW  = LOG + 1;
  localparam int PW  = LOG + 2;
  localparam int LVW = $clog2(LOG + 2);
  localparam int W   = WIDTH;
  localparam int DW  = 3 * W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PSEL, S_PRD, S_ARD, S_AMUL, S_AWR,
    S_LSEL, S_QACC, S_USEL, S_URD1, S_URD2, S_OUT
  } state_e;

  state_e         state_q, ret_q;
  logic [AW-1:0]  clr_q, a_q, k_q;
  logic           is_query_q, is_add_q, side_q, sub_q, child_q;
  logic [W-1:0]   val_q, fm_q, fa_q, pd_q, pm_q, pa_q, tmp_q, acc_q;
  logic [PW-1:0]  l0_q, r0_q, l_q, r_q;
  logic [LVW-1:0] lvl_q, h_q, sh_q;
  logic           out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;
  logic [W-1:0]  rd_sum, rd_mul, rd_add;

  raus_ram #(.AW(AW), .DW(DW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_sum = mem_rdata[DW-1:2*W];
  assign rd_mul = mem_rdata[2*W-1:W];
  assign rd_add = mem_rdata[W-1:0];

  // request decode
  logic [31:0]   lo32, hi32, hic32;
  logic          empty;
  assign lo32  = 32'(range_low_i);
  assign hi32  = 32'(range_high_i);
  assign hic32 = (hi32 >= 32'(LEAVES)) ? 32'(LEAVES - 1) : hi32;
  assign empty = (lo32 >= 32'(LEAVES)) || (range_low_i > range_high_i);

  // boundary node at the current level, and whether it is only partly covered
  logic [PW-1:0] mask;
  logic [AW-1:0] psel_k, lnode;
  logic          cond;
  assign mask   = (PW'(1) << lvl_q) - PW'(1);
  assign psel_k = side_q ? AW'((r0_q - PW'(1)) >> lvl_q) : AW'(l0_q >> lvl_q);
  assign cond   = side_q ? ((r0_q & mask) != '0) : ((l0_q & mask) != '0);
  assign lnode  = sub_q ? AW'(r_q - PW'(1)) : AW'(l_q);

  logic push_last, upd_last;
  assign push_last = side_q && (lvl_q == LVW'(1));
  assign upd_last  = side_q && (lvl_q == LVW'(LOG));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = a_q;
    mem_wdata = {pd_q + (fa_q << sh_q), pm_q, pa_q + fa_q};
    mem_raddr = a_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {W'(0), W'(1), W'(0)};
      end
      S_PSEL: mem_raddr = psel_k;
      S_PRD: begin
        mem_we    = 1'b1;
        mem_waddr = k_q;
        mem_wdata = {rd_sum, W'(1), W'(0)};
      end
      S_AWR:  mem_we = 1'b1;
      S_LSEL: mem_raddr = lnode;
      S_USEL: mem_raddr = psel_k << 1;
      S_URD1: mem_raddr = (k_q << 1) | AW'(1);
      S_URD2: begin
        mem_we    = 1'b1;
        mem_waddr = k_q;
        mem_wdata = {tmp_q + rd_sum, W'(1), W'(0)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      side_q      <= 1'b0;
      sub_q       <= 1'b0;
      child_q     <= 1'b0;
      is_query_q  <= 1'b0;
      is_add_q    <= 1'b0;
      lvl_q       <= '0;
      h_q         <= '0;
      sh_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            is_query_q <= (action_i == ACT_QUERY);
            is_add_q   <= (action_i == ACT_ADD);
            val_q      <= W'(operand_i);
            acc_q      <= '0;
            l0_q       <= PW'(lo32 + 32'(SZ));
            r0_q       <= PW'(hic32 + 32'(SZ) + 32'd1);
            lvl_q      <= LVW'(LOG);
            side_q     <= 1'b0;
            if (action_i == ACT_QUERY && empty) begin
              state_q <= S_OUT;
            end else if ((action_i == ACT_ADD || action_i == ACT_MUL ||
                          action_i == ACT_QUERY) && !empty) begin
              state_q <= S_PSEL;
            end
          end
        end
        S_PSEL: begin
          // push pending maps down the two boundary paths, root first
          if (push_last) begin
            side_q <= 1'b0;
            l_q    <= l0_q;
            r_q    <= r0_q;
            sub_q  <= 1'b0;
            h_q    <= '0;
          end else if (side_q) begin
            side_q <= 1'b0;
            lvl_q  <= lvl_q - LVW'(1);
          end else begin
            side_q <= 1'b1;
          end
          if (cond) begin
            k_q     <= psel_k;
            sh_q    <= lvl_q - LVW'(1);
            ret_q   <= push_last ? S_LSEL : S_PSEL;
            state_q <= S_PRD;
          end else begin
            state_q <= push_last ? S_LSEL : S_PSEL;
          end
        end
        S_PRD: begin
          fm_q    <= rd_mul;
          fa_q    <= rd_add;
          a_q     <= k_q << 1;
          child_q <= 1'b0;
          state_q <= S_ARD;
        end
        S_ARD: state_q <= S_AMUL;
        S_AMUL: begin
          pd_q    <= rd_sum * fm_q;
          pm_q    <= rd_mul * fm_q;
          pa_q    <= rd_add * fm_q;
          state_q <= S_AWR;
        end
        S_AWR: begin
          if (!child_q) begin
            a_q     <= a_q + AW'(1);
            child_q <= 1'b1;
            state_q <= S_ARD;
          end else begin
            state_q <= ret_q;
          end
        end
        S_LSEL: begin
          if (!sub_q && (l_q >= r_q)) begin
            if (is_query_q) begin
              state_q <= S_OUT;
            end else begin
              lvl_q   <= LVW'(1);
              side_q  <= 1'b0;
              state_q <= S_USEL;
            end
          end else begin
            if (!sub_q) begin
              sub_q <= 1'b1;
              if (l_q[0]) begin
                l_q <= l_q + PW'(1);
              end
            end else begin
              sub_q <= 1'b0;
              l_q   <= l_q >> 1;
              r_q   <= r_q >> 1;
              h_q   <= h_q + LVW'(1);
            end
            if (sub_q ? r_q[0] : l_q[0]) begin
              if (is_query_q) begin
                state_q <= S_QACC;
              end else begin
                a_q     <= lnode;
                fm_q    <= is_add_q ? W'(1) : val_q;
                fa_q    <= is_add_q ? val_q : W'(0);
                sh_q    <= h_q;
                child_q <= 1'b1;
                ret_q   <= S_LSEL;
                state_q <= S_ARD;
              end
            end
          end
        end
        S_QACC: begin
          acc_q   <= acc_q + rd_sum;
          state_q <= S_LSEL;
        end
        S_USEL: begin
          // refresh parent sums on the boundary paths, leaves first
          if (upd_last) begin
            side_q <= 1'b0;
          end else if (side_q) begin
            side_q <= 1'b0;
            lvl_q  <= lvl_q + LVW'(1);
          end else begin
            side_q <= 1'b1;
          end
          if (cond) begin
            k_q     <= psel_k;
            ret_q   <= upd_last ? S_IDLE : S_USEL;
            state_q <= S_URD1;
          end else begin
            state_q <= upd_last ? S_IDLE : S_USEL;
          end
        end
        S_URD1: begin
          tmp_q   <= rd_sum;
          state_q <= S_URD2;
        end
        S_URD2: state_q <= ret_q;
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= OUT_W'(acc_q);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_data_q;

endmodule

>>> src/raus_checker.sv
// port-level checker for the range sum unit, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module raus_checker
  import raus_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [ACT_W-1:0]  action_i,
  input logic [IDX_W-1:0]  range_low_i,
  input logic [IDX_W-1:0]  range_high_i,
  input logic [OPND_W-1:0] operand_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [OUT_W-1:0]  range_sum_o
);

  // queries taken but not yet delivered
  logic [1:0] pend_q;
  logic       q_in, q_out;
  logic       in_stall;
  logic [ACT_W+2*IDX_W+OPND_W-1:0] in_req;

  assign q_in     = in_valid_i && in_ready_o && (action_i == ACT_QUERY);
  assign q_out    = out_valid_o && out_ready_i;
  assign in_stall = in_valid_i && !in_ready_o;
  assign in_req   = {action_i, range_low_i, range_high_i, operand_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (q_in && !q_out) begin
      pend_q <= pend_q + 2'd1;
    end else if (!q_in && q_out) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  `RAUS_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(range_sum_o),
    "result dropped or changed while stalled")
  `RAUS_ASSERT(a_out_has_query, clk_i, rst_ni, out_valid_o |-> pend_q != 2'd0,
    "result without a query request")
  `RAUS_ASSERT(a_pend_bound, clk_i, rst_ni, pend_q != 2'd3, "too many queries outstanding")
  `RAUS_ASSERT(a_in_hold, clk_i, rst_ni, in_stall |=> in_valid_i && $stable(in_req),
    "request dropped or changed while waiting")
  `RAUS_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o && !in_ready_o,
    "activity right after reset")

endmodule

bind range_affine_update_range_sum_unit raus_checker u_raus_checker (.*);
